### sv/fapeb_pkg.sv
// shared types, widths and helpers for the four-anode position event builder
// no dependencies; imported by every module of the block
package fapeb_pkg;

    // anode amplitude width and fraction bits of the position quotient
    localparam int AMP_BITS    = 16;
    localparam int FRAC_BITS   = 15;
    localparam int NUM_ANODES  = 4;

    localparam int PAIR_W      = AMP_BITS + 1;
    localparam int SUM_W       = AMP_BITS + 2;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int CNT_W       = $clog2(FRAC_BITS + 1);
    localparam int EXT_W       = (Q_W > 17) ? Q_W : 17;
    localparam int IDX_W       = $clog2(NUM_ANODES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int POS_MAX     = 32767;
    localparam int POS_MIN_MAG = 32768;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_DYNODE = 2'd1;
    localparam logic [1:0] OP_ANODE  = 2'd2;

    // anode positions
    localparam logic [IDX_W-1:0] AN_SE = IDX_W'(0);
    localparam logic [IDX_W-1:0] AN_NE = IDX_W'(1);
    localparam logic [IDX_W-1:0] AN_NW = IDX_W'(2);
    localparam logic [IDX_W-1:0] AN_SW = IDX_W'(3);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  anode_index;
        logic [15:0] amplitude;
        logic [47:0] hit_time;
        logic [31:0] charge_long;
        logic [31:0] charge_short;
    } t_in_item;

    typedef struct packed {
        logic               complete;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [47:0]        dyn_time_out;
        logic [31:0]        dyn_long_out;
        logic [31:0]        dyn_short_out;
    } t_out_item;

    typedef logic [AMP_BITS-1:0] t_amp;

    // snapshot of the event after one item, handed from front to back
    typedef struct packed {
        logic                       complete;
        t_amp [NUM_ANODES-1:0]      anode;
        logic [47:0]                dyn_time;
        logic [31:0]                dyn_long;
        logic [31:0]                dyn_short;
    } t_job;

    // saturate a magnitude quotient with sign to the 16-bit position range
    function automatic logic [15:0] sat_pos(input logic neg, input logic [Q_W-1:0] q);
        logic [EXT_W-1:0] qe;
        logic [15:0]      res;
        qe = EXT_W'(q);
        if (!neg) begin
            if (qe > EXT_W'(POS_MAX)) begin
                res = 16'(POS_MAX);
            end else begin
                res = qe[15:0];
            end
        end else begin
            if (qe > EXT_W'(POS_MIN_MAG)) begin
                res = 16'(POS_MIN_MAG);
            end else begin
                res = 16'(0) - qe[15:0];
            end
        end
        return res;
    endfunction

endpackage

### sv/fapeb_front.sv
// front part: accepts hit items and keeps the event (dynode and anode records)
// depends on fapeb_pkg; pushes one event snapshot per item into the job queue
module fapeb_front
    import fapeb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_job     o_job
);

    logic                  r_dyn_seen;
    logic [NUM_ANODES-1:0] r_anode_seen;
    t_amp                  r_anode [NUM_ANODES];
    logic [47:0]           r_dyn_time;
    logic [31:0]           r_dyn_long;
    logic [31:0]           r_dyn_short;

    logic                  n_dyn_seen;
    logic [NUM_ANODES-1:0] n_anode_seen;
    logic [47:0]           n_dyn_time;
    logic [31:0]           n_dyn_long;
    logic [31:0]           n_dyn_short;
    t_amp                  w_amp;
    logic                  w_anode_wr;
    logic [IDX_W-1:0]      w_idx;

    assign w_amp      = AMP_BITS'(i_item.amplitude);
    assign w_idx      = IDX_W'(i_item.anode_index);
    assign w_anode_wr = (i_item.opcode == OP_ANODE) && (w_amp != '0);

    always_comb begin
        n_dyn_seen   = r_dyn_seen;
        n_anode_seen = r_anode_seen;
        n_dyn_time   = r_dyn_time;
        n_dyn_long   = r_dyn_long;
        n_dyn_short  = r_dyn_short;
        case (i_item.opcode)
            OP_CLEAR: begin
                n_dyn_seen   = 1'b0;
                n_anode_seen = '0;
                n_dyn_time   = '0;
                n_dyn_long   = '0;
                n_dyn_short  = '0;
            end
            OP_DYNODE: begin
                n_dyn_seen  = 1'b1;
                n_dyn_time  = i_item.hit_time;
                n_dyn_long  = i_item.charge_long;
                n_dyn_short = i_item.charge_short;
            end
            OP_ANODE: begin
                if (w_anode_wr) begin
                    n_anode_seen[w_idx] = 1'b1;
                end
            end
            default: begin
                // unused opcode leaves the event alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_seen   <= 1'b0;
            r_anode_seen <= '0;
            r_dyn_time   <= '0;
            r_dyn_long   <= '0;
            r_dyn_short  <= '0;
        end else if (i_accept) begin
            r_dyn_seen   <= n_dyn_seen;
            r_anode_seen <= n_anode_seen;
            r_dyn_time   <= n_dyn_time;
            r_dyn_long   <= n_dyn_long;
            r_dyn_short  <= n_dyn_short;
        end
    end

    // anode amplitudes hold no reset, read only once their seen bit is set
    always_ff @(posedge i_clk) begin
        if (i_accept && w_anode_wr) begin
            r_anode[w_idx] <= w_amp;
        end
    end

    // snapshot seen by the back end, with this item applied
    always_comb begin
        o_job.complete  = n_dyn_seen && (&n_anode_seen);
        o_job.dyn_time  = n_dyn_time;
        o_job.dyn_long  = n_dyn_long;
        o_job.dyn_short = n_dyn_short;
        for (int i = 0; i < NUM_ANODES; i++) begin
            if (w_anode_wr && (w_idx == IDX_W'(i))) begin
                o_job.anode[i] = w_amp;
            end else begin
                o_job.anode[i] = r_anode[i];
            end
        end
    end

endmodule

### sv/fapeb_queue.sv
// short job queue between the front and the back part
// depends on fapeb_pkg for the job type and depth
module fapeb_queue
    import fapeb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### sv/fapeb_back.sv
// back part: takes event snapshots, runs the bit-serial anger-logic divide
// depends on fapeb_pkg; holds the last position and the result register
module fapeb_back
    import fapeb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_job,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_pop,
    output t_out_item o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [15:0]        r_x;
    logic [15:0]        r_y;
    logic [SUM_W-1:0]   r_den;
    logic [SUM_W-1:0]   r_rem_x;
    logic [SUM_W-1:0]   r_rem_y;
    logic [Q_W-1:0]     r_q_x;
    logic [Q_W-1:0]     r_q_y;
    logic               r_neg_x;
    logic               r_neg_y;
    logic [CNT_W-1:0]   r_cnt;

    logic [PAIR_W-1:0]  w_px, w_mx, w_py, w_my;
    logic [SUM_W-1:0]   w_total, w_mag_x, w_mag_y;
    logic [SUM_W:0]     w_tr_x, w_tr_y;
    logic [SUM_W-1:0]   n_rem_x, n_rem_y;
    logic [Q_W-1:0]     n_q_x, n_q_y;
    logic [15:0]        w_sat_x, w_sat_y;

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // paired anode sums: x = (SE+NE)-(NW+SW), y = (NE+NW)-(SE+SW)
    always_comb begin
        w_px    = PAIR_W'(r_job.anode[AN_SE]) + PAIR_W'(r_job.anode[AN_NE]);
        w_mx    = PAIR_W'(r_job.anode[AN_NW]) + PAIR_W'(r_job.anode[AN_SW]);
        w_py    = PAIR_W'(r_job.anode[AN_NE]) + PAIR_W'(r_job.anode[AN_NW]);
        w_my    = PAIR_W'(r_job.anode[AN_SE]) + PAIR_W'(r_job.anode[AN_SW]);
        w_total = SUM_W'(w_px) + SUM_W'(w_mx);
        w_mag_x = (w_px >= w_mx) ? SUM_W'(w_px - w_mx) : SUM_W'(w_mx - w_px);
        w_mag_y = (w_py >= w_my) ? SUM_W'(w_py - w_my) : SUM_W'(w_my - w_py);
    end

    // one restoring step per cycle; the first step takes the integer bit
    always_comb begin
        if (r_cnt == '0) begin
            w_tr_x = {1'b0, r_rem_x};
            w_tr_y = {1'b0, r_rem_y};
        end else begin
            w_tr_x = {r_rem_x, 1'b0};
            w_tr_y = {r_rem_y, 1'b0};
        end
        if (w_tr_x >= {1'b0, r_den}) begin
            n_rem_x = SUM_W'(w_tr_x - {1'b0, r_den});
            n_q_x   = {r_q_x[Q_W-2:0], 1'b1};
        end else begin
            n_rem_x = SUM_W'(w_tr_x);
            n_q_x   = {r_q_x[Q_W-2:0], 1'b0};
        end
        if (w_tr_y >= {1'b0, r_den}) begin
            n_rem_y = SUM_W'(w_tr_y - {1'b0, r_den});
            n_q_y   = {r_q_y[Q_W-2:0], 1'b1};
        end else begin
            n_rem_y = SUM_W'(w_tr_y);
            n_q_y   = {r_q_y[Q_W-2:0], 1'b0};
        end
    end

    assign w_sat_x = sat_pos(r_neg_x, r_q_x);
    assign w_sat_y = sat_pos(r_neg_y, r_q_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_job <= i_job;
                        if (i_job.complete) begin
                            r_state <= S_LOAD;
                        end else begin
                            // incomplete event reports the last position
                            r_out_valid         <= 1'b1;
                            r_out.complete      <= 1'b0;
                            r_out.x_pos         <= $signed(r_x);
                            r_out.y_pos         <= $signed(r_y);
                            r_out.dyn_time_out  <= i_job.dyn_time;
                            r_out.dyn_long_out  <= i_job.dyn_long;
                            r_out.dyn_short_out <= i_job.dyn_short;
                        end
                    end
                end
                S_LOAD: begin
                    r_den   <= w_total;
                    r_rem_x <= w_mag_x;
                    r_rem_y <= w_mag_y;
                    r_neg_x <= (w_px < w_mx);
                    r_neg_y <= (w_py < w_my);
                    r_q_x   <= '0;
                    r_q_y   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem_x <= n_rem_x;
                    r_rem_y <= n_rem_y;
                    r_q_x   <= n_q_x;
                    r_q_y   <= n_q_y;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(FRAC_BITS)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_x                 <= w_sat_x;
                    r_y                 <= w_sat_y;
                    r_out_valid         <= 1'b1;
                    r_out.complete      <= 1'b1;
                    r_out.x_pos         <= $signed(w_sat_x);
                    r_out.y_pos         <= $signed(w_sat_y);
                    r_out.dyn_time_out  <= r_job.dyn_time;
                    r_out.dyn_long_out  <= r_job.dyn_long;
                    r_out.dyn_short_out <= r_job.dyn_short;
                    r_cnt               <= '0;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/four_anode_position_event_builder_unit.sv
// top level of the four-anode position event builder
// depends on fapeb_pkg, fapeb_front, fapeb_queue and fapeb_back
//
// Builds one position-sensitive photomultiplier event from a stream of hit
// items and returns exactly one result per item, in order. Items go in through
// push/full and results come out through empty/pop, both queue style. An item
// clears the event, records the dynode hit, or records one anode amplitude (a
// zero amplitude is dropped). Once the dynode and all four anodes are present,
// x and y are computed in signed Q1.15 by anger logic, truncated toward zero
// and saturated; an incomplete event reports the last computed position. An
// item is taken by the front end, which holds the event record, and passes
// through a two-entry job queue to the back end. An incomplete event reaches
// the result register at the edge that picks it up from the queue; a complete
// one is picked up, then its anode sums are formed, then divide steps produce
// the integer bit and the 15 fraction bits, then the result is saturated. The
// next job is picked up only while the result register is empty, so even with
// pop held high the back end takes another job only after the result has left.
// The queue takes new items while the back end is busy, until it is full; the
// back end's bit-serial divider pair for x and y limits the result rate.
module four_anode_position_event_builder_unit
    import fapeb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    // front to queue
    logic w_accept;
    t_job w_front_job;
    logic w_q_full;

    // queue to back
    logic w_q_empty;
    logic w_q_pop;
    t_job w_q_job;

    // result register
    logic w_out_valid;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;
    assign empty    = !w_out_valid;

    // event record and classification of each item
    fapeb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_job    (w_front_job)
    );

    // decouples item intake from the divide
    fapeb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    // position divide and result register
    fapeb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_job       (w_q_job),
        .o_q_pop     (w_q_pop),
        .o_out_valid (w_out_valid),
        .i_out_pop   (pop),
        .o_out       (o_result)
    );

    // back end never takes a job from an empty queue
    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("job taken from empty queue");

    // back end takes a job only while no result waits to be transferred
    a_pop_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> empty)
        else $error("job taken while result register occupied");

    // a transfer into the block always lands in the queue
    a_accept_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_q_pop) |=> !w_q_empty)
        else $error("accepted item lost");

    // nothing is offered right after reset
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("result offered after reset");

endmodule
